[design/bpa_pkg.sv]
// Shared types, codes and constants for the bitmap page allocator.
// No dependencies; every other design file but bpa_stream_if refers to this package by scoped names.
package bpa_pkg;

    localparam int unsigned WORD_BITS      = 32;
    localparam int unsigned PAGE_BYTES     = 4096;
    localparam int unsigned PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int unsigned MAX_PAGES_DEF  = 32768;
    localparam logic [15:0] PAGE_COUNT_RST = 16'd32768;

    // Request operation codes.
    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_CHANGED = 2'd0;
    localparam logic [1:0] STAT_SAME    = 2'd1;
    localparam logic [1:0] STAT_NO_FREE = 2'd2;
    localparam logic [1:0] STAT_RANGE   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_address;
        logic [15:0] used_pages;
        logic [15:0] free_pages;
    } rsp_t;

    typedef struct packed {
        logic [15:0] page_count;
    } cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_RESP
    } state_t;

    // Index of the lowest clear bit of a word that is known not to be all ones.
    function automatic logic [4:0] first_zero(input logic [WORD_BITS-1:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!v[k]) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

endpackage

[design/bpa_stream_if.sv]
// Valid/ready channel interface used for requests, results and configuration.
// The payload type is a parameter, normally a struct from bpa_pkg.
interface bpa_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/bpa_bitmap_ram.sv]
// Single-port-write, single-port-read bitmap word memory with registered read data.
// Depends on bpa_pkg for the word width.
module bpa_bitmap_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [bpa_pkg::WORD_BITS-1:0]  wr_data,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [bpa_pkg::WORD_BITS-1:0]  rd_data
);

    logic [bpa_pkg::WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/bitmap_page_allocator.sv]
// Bitmap page allocator, first fit. One used bit per page is kept in a memory of 32-bit
// words, with a count of used pages in a register. Each request beat marks a page used,
// frees a page, or allocates the lowest free page; each produces exactly one result beat
// with a status, the allocated byte address and the used and free counts, unless a page
// count write cuts the request off. A mark or free runs decode and word read, modify and
// write back, then result load once the output register is free. An allocation stays in
// the modify step while it reads full bitmap words, as the search reads one memory word per
// cycle. A request that is out of range, carries the unused code, or finds no searchable
// word left skips the memory. The next request can be accepted in the cycle after the
// result register loads, so requests are handled one at a time.
// A search hint register holds the lowest word that may still have a free page, so
// the search normally starts at its target; in the worst case it walks every whole word
// below the page count. After reset, and after every write of the page count register,
// a clearing pass sets every bitmap word to all ones, one word per cycle; no request is
// accepted until it completes, while configuration beats are always accepted. Only whole
// 32-page words below the page count are searched, so pages of a partial last word can be
// marked and freed but not allocated. Mark and free addresses whose page lies at or above
// the page count report out of range and change nothing. A finished result waits in the
// output register while the next request runs.
module bitmap_page_allocator #(
    parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bpa_stream_if.sink    cfg,
    bpa_stream_if.sink    req,
    bpa_stream_if.source  rsp
);

    localparam int unsigned MAP_WORDS = (MAX_PAGES + 31) / 32;
    localparam int unsigned WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    // Wide enough to hold MAP_WORDS itself, used by the search hint.
    localparam int unsigned CNT_W     = WIDX_W + 1;
    localparam int unsigned LIMIT_CAP = (MAX_PAGES > 65535) ? 65535 : MAX_PAGES;
    localparam logic [15:0] CAP16     = 16'(LIMIT_CAP);
    localparam logic [15:0] LIMIT_RST = (bpa_pkg::PAGE_COUNT_RST > CAP16) ? CAP16
                                                                         : bpa_pkg::PAGE_COUNT_RST;
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);
    localparam logic [CNT_W-1:0]  HINT_ALL_FULL = CNT_W'(MAP_WORDS);

    bpa_pkg::state_t state_reg, state_next;

    logic [15:0]       limit_reg, limit_next;
    logic [15:0]       used_reg, used_next;
    logic [CNT_W-1:0]  hint_reg, hint_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [WIDX_W-1:0] clr_reg, clr_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       page_reg, page_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [31:0]       res_addr_reg, res_addr_next;
    logic              out_valid_reg, out_valid_next;
    bpa_pkg::rsp_t     out_data_reg, out_data_next;

    // Memory port controls.
    logic                           wr_en;
    logic [WIDX_W-1:0]              wr_addr;
    logic [bpa_pkg::WORD_BITS-1:0]  wr_data;
    logic                           rd_en;
    logic [WIDX_W-1:0]              rd_addr;
    logic [bpa_pkg::WORD_BITS-1:0]  rd_data;

    // Decoded request and word information.
    logic                           cfg_fire;
    logic                           req_fire;
    logic                           out_free;
    logic [15:0]                    cfg_limit;
    logic [10:0]                    words;
    logic                           page_in_range;
    logic [WIDX_W-1:0]              page_widx;
    logic [bpa_pkg::WORD_BITS-1:0]  bit_mask;
    logic                           bit_set;
    logic                           word_full;
    logic [4:0]                     free_bit;
    logic [CNT_W-1:0]               scan_inc;
    logic                           scan_last;
    logic                           hint_at_end;
    logic [31:0]                    alloc_addr;

    bpa_bitmap_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WIDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == bpa_pkg::S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign cfg_fire = cfg.valid & cfg.ready;
    assign req_fire = req.valid & req.ready;
    // The result register can take a new beat when empty or being drained this cycle.
    assign out_free = !out_valid_reg || rsp.ready;

    // The effective page count saturates at the bitmap capacity.
    assign cfg_limit = (cfg.data.page_count > CAP16) ? CAP16 : cfg.data.page_count;
    // Only whole words below the page count take part in allocation.
    assign words = limit_reg[15:5];

    assign page_in_range = (page_reg < {16'd0, limit_reg});
    assign page_widx     = page_reg[WIDX_W+4:5];
    assign bit_mask      = 32'd1 << page_reg[4:0];
    assign bit_set       = |(rd_data & bit_mask);
    assign word_full     = &rd_data;
    assign free_bit      = bpa_pkg::first_zero(rd_data);
    assign scan_inc      = scan_reg + CNT_W'(1);
    assign scan_last     = (32'(scan_inc) >= 32'(words));
    assign hint_at_end   = (32'(hint_reg) >= 32'(words));
    assign alloc_addr    = 32'({scan_reg[WIDX_W-1:0], free_bit}) << bpa_pkg::PAGE_SHIFT;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_WORD)
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = bpa_pkg::S_DECODE;
                end
            end
            bpa_pkg::S_DECODE:
            begin
                state_next = bpa_pkg::S_RESP;
                case (op_reg) inside
                    bpa_pkg::OP_MARK, bpa_pkg::OP_FREE:
                    begin
                        if (page_in_range)
                        begin
                            state_next = bpa_pkg::S_EXEC;
                        end
                    end
                    bpa_pkg::OP_ALLOC:
                    begin
                        if (!hint_at_end)
                        begin
                            state_next = bpa_pkg::S_EXEC;
                        end
                    end
                    default:
                    begin
                        state_next = bpa_pkg::S_RESP;
                    end
                endcase
            end
            bpa_pkg::S_EXEC:
            begin
                // A search stays here while it reads full words and has more to read.
                if (op_reg == bpa_pkg::OP_ALLOC && word_full && !scan_last)
                begin
                    state_next = bpa_pkg::S_EXEC;
                end
                else
                begin
                    state_next = bpa_pkg::S_RESP;
                end
            end
            bpa_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::S_CLEAR;
            end
        endcase
        // A page count write restarts the clearing pass.
        if (cfg_fire)
        begin
            state_next = bpa_pkg::S_CLEAR;
        end
    end

    // Datapath and memory control.
    always_comb
    begin
        limit_next      = limit_reg;
        used_next       = used_reg;
        hint_next       = hint_reg;
        scan_next       = scan_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = page_widx;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = page_widx;

        unique case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '1;
                clr_next = clr_reg + WIDX_W'(1);
            end
            bpa_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next   = req.data.op;
                    page_next = req.data.address >> bpa_pkg::PAGE_SHIFT;
                end
            end
            bpa_pkg::S_DECODE:
            begin
                res_addr_next = '0;
                case (op_reg) inside
                    bpa_pkg::OP_MARK, bpa_pkg::OP_FREE:
                    begin
                        if (page_in_range)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = page_widx;
                        end
                        else
                        begin
                            res_status_next = bpa_pkg::STAT_RANGE;
                        end
                    end
                    bpa_pkg::OP_ALLOC:
                    begin
                        if (hint_at_end)
                        begin
                            res_status_next = bpa_pkg::STAT_NO_FREE;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = hint_reg[WIDX_W-1:0];
                            scan_next = hint_reg;
                        end
                    end
                    default:
                    begin
                        res_status_next = bpa_pkg::STAT_SAME;
                    end
                endcase
            end
            bpa_pkg::S_EXEC:
            begin
                res_status_next = bpa_pkg::STAT_SAME;
                case (op_reg)
                    bpa_pkg::OP_MARK:
                    begin
                        if (!bit_set)
                        begin
                            wr_en           = 1'b1;
                            wr_data         = rd_data | bit_mask;
                            used_next       = used_reg + 16'd1;
                            res_status_next = bpa_pkg::STAT_CHANGED;
                        end
                    end
                    bpa_pkg::OP_FREE:
                    begin
                        if (bit_set)
                        begin
                            wr_en           = 1'b1;
                            wr_data         = rd_data & ~bit_mask;
                            used_next       = used_reg - 16'd1;
                            res_status_next = bpa_pkg::STAT_CHANGED;
                            // This word now has a free page, so the search may start here.
                            if (CNT_W'(page_widx) < hint_reg)
                            begin
                                hint_next = CNT_W'(page_widx);
                            end
                        end
                    end
                    default:
                    begin
                        if (!word_full)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = scan_reg[WIDX_W-1:0];
                            wr_data         = rd_data | (32'd1 << free_bit);
                            used_next       = used_reg + 16'd1;
                            res_status_next = bpa_pkg::STAT_CHANGED;
                            res_addr_next   = alloc_addr;
                            hint_next       = scan_reg;
                        end
                        else if (scan_last)
                        begin
                            // Every whole word below the page count is full.
                            res_status_next = bpa_pkg::STAT_NO_FREE;
                            hint_next       = CNT_W'(words);
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = scan_inc[WIDX_W-1:0];
                            scan_next = scan_inc;
                        end
                    end
                endcase
            end
            bpa_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = res_status_reg;
                    out_data_next.page_address = res_addr_reg;
                    out_data_next.used_pages   = used_reg;
                    out_data_next.free_pages   = limit_reg - used_reg;
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase

        if (cfg_fire)
        begin
            limit_next = cfg_limit;
            used_next  = cfg_limit;
            hint_next  = HINT_ALL_FULL;
            clr_next   = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_CLEAR;
            limit_reg     <= LIMIT_RST;
            used_reg      <= LIMIT_RST;
            hint_reg      <= HINT_ALL_FULL;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            used_reg      <= used_next;
            hint_reg      <= hint_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        op_reg         <= op_next;
        page_reg       <= page_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_data_reg   <= out_data_next;
    end

endmodule

[design/bpa_checker.sv]
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg for the result type and status codes.
module bpa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cfg_valid,
    input logic          cfg_ready,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bpa_pkg::rsp_t rsp_data
);

    // A stalled result beat stays and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result beat dropped or changed while stalled");

    // Only a result with the changed status may report a nonzero page address.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != bpa_pkg::STAT_CHANGED |->
        rsp_data.page_address == 32'd0)
    else $error("page address reported without a successful allocation");

    // A page count write starts the clearing pass, which holds off requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !req_ready)
    else $error("request accepted right after a page count write");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
